### sv/scancode_to_ascii_with_fifo_macros.svh
// Assertion helpers shared by the keyboard decoder files.
// Each expects clk and arst_n in scope.
`ifndef SCANCODE_TO_ASCII_WITH_FIFO_MACROS_SVH
`define SCANCODE_TO_ASCII_WITH_FIFO_MACROS_SVH

// Same-cycle implication.
`define SC2ASC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SC2ASC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/sc2asc_pkg.sv
package sc2asc_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

	localparam int KEY_COUNT = 59;

	localparam logic [7:0] CODE_ERROR     = 8'hFE;
	localparam logic [7:0] CODE_TAB       = 8'h0F;
	localparam logic [7:0] CODE_BACKSPACE = 8'h0E;
	localparam logic [7:0] CODE_ENTER     = 8'h1C;
	localparam logic [7:0] CODE_LSHIFT    = 8'h2A;
	localparam logic [7:0] CODE_RSHIFT    = 8'h36;
	localparam logic [7:0] CODE_LSHIFT_UP = 8'hAA;
	localparam logic [7:0] CODE_RSHIFT_UP = 8'hB6;
	localparam logic [7:0] CODE_CAPS      = 8'h3A;
	localparam logic [7:0] CODE_NUM       = 8'h45;
	localparam logic [7:0] CODE_SCROLL    = 8'h46;

	localparam logic [6:0] CHAR_TAB       = 7'd9;
	localparam logic [6:0] CHAR_BACKSPACE = 7'd8;
	localparam logic [6:0] CHAR_ENTER     = 7'd10;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] scan_code;
	} cmd_t;

	typedef struct packed {
		logic       read_valid;
		logic [6:0] read_char;
		logic       echo_valid;
		logic [6:0] echo_char;
		logic       led_write;
		logic [2:0] led_bits;
		logic       overflow;
		logic       kbd_error;
	} rsp_t;

	// What one scan code asks of the datapath.
	typedef struct packed {
		logic       err;
		logic       echo_v;
		logic [6:0] echo_ch;
		logic       push;
		logic [6:0] push_ch;
		logic       tog_caps;
		logic       tog_num;
		logic       tog_scroll;
		logic       shift_set;
		logic       shift_clr;
	} action_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic [6:0] wdata;
	} fifo_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [6:0] plain_char(input logic [5:0] idx);
		logic [6:0] ch;
		ch = 7'h00;
		case (idx)
			6'd2:  ch = 7'h31;
			6'd3:  ch = 7'h32;
			6'd4:  ch = 7'h33;
			6'd5:  ch = 7'h34;
			6'd6:  ch = 7'h35;
			6'd7:  ch = 7'h36;
			6'd8:  ch = 7'h37;
			6'd9:  ch = 7'h38;
			6'd10: ch = 7'h39;
			6'd11: ch = 7'h30;
			6'd12: ch = 7'h2D;
			6'd13: ch = 7'h3D;
			6'd16: ch = 7'h71;
			6'd17: ch = 7'h77;
			6'd18: ch = 7'h65;
			6'd19: ch = 7'h72;
			6'd20: ch = 7'h74;
			6'd21: ch = 7'h79;
			6'd22: ch = 7'h75;
			6'd23: ch = 7'h69;
			6'd24: ch = 7'h6F;
			6'd25: ch = 7'h70;
			6'd26: ch = 7'h5B;
			6'd27: ch = 7'h5D;
			6'd30: ch = 7'h61;
			6'd31: ch = 7'h73;
			6'd32: ch = 7'h64;
			6'd33: ch = 7'h66;
			6'd34: ch = 7'h67;
			6'd35: ch = 7'h68;
			6'd36: ch = 7'h6A;
			6'd37: ch = 7'h6B;
			6'd38: ch = 7'h6C;
			6'd39: ch = 7'h3B;
			6'd40: ch = 7'h27;
			6'd41: ch = 7'h60;
			6'd43: ch = 7'h5C;
			6'd44: ch = 7'h7A;
			6'd45: ch = 7'h78;
			6'd46: ch = 7'h63;
			6'd47: ch = 7'h76;
			6'd48: ch = 7'h62;
			6'd49: ch = 7'h6E;
			6'd50: ch = 7'h6D;
			6'd51: ch = 7'h2C;
			6'd52: ch = 7'h2E;
			6'd53: ch = 7'h2F;
			6'd57: ch = 7'h20;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [6:0] shifted_char(input logic [5:0] idx);
		logic [6:0] ch;
		ch = 7'h00;
		case (idx)
			6'd2:  ch = 7'h21;
			6'd3:  ch = 7'h40;
			6'd4:  ch = 7'h23;
			6'd5:  ch = 7'h24;
			6'd6:  ch = 7'h25;
			6'd7:  ch = 7'h5E;
			6'd8:  ch = 7'h26;
			6'd9:  ch = 7'h2A;
			6'd10: ch = 7'h28;
			6'd11: ch = 7'h29;
			6'd12: ch = 7'h5F;
			6'd13: ch = 7'h2B;
			6'd16: ch = 7'h51;
			6'd17: ch = 7'h57;
			6'd18: ch = 7'h45;
			6'd19: ch = 7'h52;
			6'd20: ch = 7'h54;
			6'd21: ch = 7'h59;
			6'd22: ch = 7'h55;
			6'd23: ch = 7'h49;
			6'd24: ch = 7'h4F;
			6'd25: ch = 7'h50;
			6'd26: ch = 7'h7B;
			6'd27: ch = 7'h7D;
			6'd30: ch = 7'h41;
			6'd31: ch = 7'h53;
			6'd32: ch = 7'h44;
			6'd33: ch = 7'h46;
			6'd34: ch = 7'h47;
			6'd35: ch = 7'h48;
			6'd36: ch = 7'h4A;
			6'd37: ch = 7'h4B;
			6'd38: ch = 7'h4C;
			6'd39: ch = 7'h3A;
			6'd40: ch = 7'h22;
			6'd41: ch = 7'h7E;
			6'd43: ch = 7'h7C;
			6'd44: ch = 7'h5A;
			6'd45: ch = 7'h58;
			6'd46: ch = 7'h43;
			6'd47: ch = 7'h56;
			6'd48: ch = 7'h42;
			6'd49: ch = 7'h4E;
			6'd50: ch = 7'h4D;
			6'd51: ch = 7'h3C;
			6'd52: ch = 7'h3E;
			6'd53: ch = 7'h3F;
			6'd57: ch = 7'h20;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

### sv/sc2asc_decode.sv
module sc2asc_decode (
	input  logic [7:0]          code,
	input  logic                shift_held,
	input  logic                caps_on,
	output sc2asc_pkg::action_t act
);

	logic [6:0] map_ch;
	logic       letter;
	logic [6:0] key_ch;

	always_comb begin
		map_ch = shift_held ? sc2asc_pkg::shifted_char(code[5:0])
		                    : sc2asc_pkg::plain_char(code[5:0]);
		letter = (map_ch >= 7'h61 && map_ch <= 7'h7A) || (map_ch >= 7'h41 && map_ch <= 7'h5A);
		key_ch = (caps_on && letter) ? (map_ch ^ 7'h20) : map_ch;
	end

	always_comb begin
		act = '0;
		if (code == sc2asc_pkg::CODE_ERROR) begin
			act.err = 1'b1;
		end else if (code == sc2asc_pkg::CODE_TAB) begin
			act.echo_v  = 1'b1;
			act.echo_ch = sc2asc_pkg::CHAR_TAB;
		end else if (code == sc2asc_pkg::CODE_CAPS) begin
			act.tog_caps = 1'b1;
		end else if (code == sc2asc_pkg::CODE_NUM) begin
			act.tog_num = 1'b1;
		end else if (code == sc2asc_pkg::CODE_SCROLL) begin
			act.tog_scroll = 1'b1;
		end else if (code == sc2asc_pkg::CODE_BACKSPACE) begin
			act.push    = 1'b1;
			act.push_ch = sc2asc_pkg::CHAR_BACKSPACE;
		end else if (code == sc2asc_pkg::CODE_ENTER) begin
			act.echo_v  = 1'b1;
			act.echo_ch = sc2asc_pkg::CHAR_ENTER;
			act.push    = 1'b1;
			act.push_ch = sc2asc_pkg::CHAR_ENTER;
		end else if (code == sc2asc_pkg::CODE_LSHIFT || code == sc2asc_pkg::CODE_RSHIFT) begin
			act.shift_set = 1'b1;
		end else if (code == sc2asc_pkg::CODE_LSHIFT_UP
		             || code == sc2asc_pkg::CODE_RSHIFT_UP) begin
			act.shift_clr = 1'b1;
		end else if (code < 8'(sc2asc_pkg::KEY_COUNT) && map_ch != 7'h00) begin
			act.echo_v  = 1'b1;
			act.echo_ch = key_ch;
			act.push    = 1'b1;
			act.push_ch = key_ch;
		end
	end

endmodule

### sv/sc2asc_fifo.sv
`include "scancode_to_ascii_with_fifo_macros.svh"

module sc2asc_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sc2asc_pkg::fifo_ctl_t  ctl,
	output sc2asc_pkg::fifo_stat_t stat,
	output logic [6:0]             rd_data
);

	localparam int DEPTH = sc2asc_pkg::BUFFER_DEPTH;
	localparam int PTR_W = sc2asc_pkg::PTR_W;
	localparam int CNT_W = sc2asc_pkg::CNT_W;

	logic [6:0]       mem [DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = ctl.push && !stat.full;
	assign do_pop     = ctl.pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wp_q] <= ctl.wdata;
		end
		if (do_pop) begin
			rd_data <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SC2ASC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "fill count beyond depth")
	`SC2ASC_ASSERT_IMP(a_ptr_meet, stat.empty || stat.full, wp_q == rp_q, "pointers disagree with count")
	`SC2ASC_ASSERT_NXT(a_cnt_inc, do_push && !do_pop, cnt_q == CNT_W'($past(cnt_q) + 1'b1), "push not counted")

endmodule

### sv/scancode_to_ascii_with_fifo.sv
// channel | valid     | stall      | payload          | direction
// cmd     | cmd_valid | cmd_stall  | cmd  (cmd_t)     | in
// rsp     | rsp_valid | rsp_stall  | rsp  (rsp_t)     | out
//
// One transaction in gives exactly one transaction out, via the input register and then the result register.
// Sustained rate one transaction per cycle while rsp_stall is low; the decode and FIFO update sit between
// the input register and the result register, the FIFO read port registers the char.
// Reset clears the lock/shift flags and the FIFO pointers; FIFO storage is not cleared.
// A stalled result holds; one more transaction is taken into the input register meanwhile.
`include "scancode_to_ascii_with_fifo_macros.svh"

module scancode_to_ascii_with_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  sc2asc_pkg::cmd_t cmd,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output sc2asc_pkg::rsp_t rsp
);

	logic                   v1_q;
	sc2asc_pkg::cmd_t       cmd_s1;
	logic                   v2_q;
	sc2asc_pkg::rsp_t       res_s2;
	logic                   adv1;
	logic                   adv2;
	logic                   shift_q;
	logic                   caps_q;
	logic                   num_q;
	logic                   scroll_q;
	logic                   is_read;
	logic                   caps_nx;
	logic                   num_nx;
	logic                   scroll_nx;
	sc2asc_pkg::action_t    act;
	sc2asc_pkg::fifo_ctl_t  fctl;
	sc2asc_pkg::fifo_stat_t fstat;
	sc2asc_pkg::rsp_t       res_nx;
	logic [6:0]             rd_data;

	assign adv2      = !v2_q || !rsp_stall;
	assign adv1      = v1_q && adv2;
	assign cmd_stall = v1_q && !adv2;
	assign rsp_valid = v2_q;
	assign is_read   = (cmd_s1.operation == sc2asc_pkg::OP_READ);

	sc2asc_decode u_decode (
		.code       (cmd_s1.scan_code),
		.shift_held (shift_q),
		.caps_on    (caps_q),
		.act        (act)
	);

	always_comb begin
		fctl.push  = adv1 && !is_read && act.push;
		fctl.pop   = adv1 && is_read;
		fctl.wdata = act.push_ch;
	end

	sc2asc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fctl),
		.stat    (fstat),
		.rd_data (rd_data)
	);

	always_comb begin
		caps_nx   = caps_q ^ act.tog_caps;
		num_nx    = num_q ^ act.tog_num;
		scroll_nx = scroll_q ^ act.tog_scroll;
		res_nx    = '0;
		if (is_read) begin
			res_nx.read_valid = !fstat.empty;
		end else begin
			res_nx.echo_valid = act.echo_v;
			res_nx.echo_char  = act.echo_ch;
			res_nx.led_write  = act.tog_caps || act.tog_num || act.tog_scroll;
			if (res_nx.led_write) begin
				res_nx.led_bits = {caps_nx, num_nx, scroll_nx};
			end
			res_nx.overflow  = act.push && fstat.full;
			res_nx.kbd_error = act.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			shift_q  <= 1'b0;
			caps_q   <= 1'b0;
			num_q    <= 1'b0;
			scroll_q <= 1'b0;
		end else begin
			if (!cmd_stall) begin
				v1_q <= cmd_valid;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
			if (adv1 && !is_read) begin
				caps_q   <= caps_nx;
				num_q    <= num_nx;
				scroll_q <= scroll_nx;
				if (act.shift_set) begin
					shift_q <= 1'b1;
				end else if (act.shift_clr) begin
					shift_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
		if (adv1) begin
			res_s2 <= res_nx;
		end
	end

	// popped char arrives from the FIFO read register alongside the result stage
	always_comb begin
		rsp           = res_s2;
		rsp.read_char = res_s2.read_valid ? rd_data : '0;
	end

	`SC2ASC_ASSERT_IMP(a_stall_held, cmd_stall, v1_q && v2_q && rsp_stall, "stall without a full pipe")
	`SC2ASC_ASSERT_IMP(a_err_alone, rsp_valid && rsp.kbd_error, !rsp.echo_valid && !rsp.led_write && !rsp.overflow, "error transaction with side effects")
	`SC2ASC_ASSERT_IMP(a_read_alone, rsp_valid && rsp.read_valid, !rsp.echo_valid && !rsp.led_write && !rsp.kbd_error, "read transaction with key effects")

endmodule
